### design/dgso_pkg.sv
// shared types, constants and helpers for the diagonal grid spot ordering unit
`timescale 1ns / 1ps
package dgso_pkg;

   localparam int MAX_SPOTS  = 256;
   localparam int IDX_BITS   = $clog2(MAX_SPOTS);
   localparam int CNT_BITS   = IDX_BITS + 1;
   localparam int COORD_BITS = 20;
   localparam int SUM_BITS   = COORD_BITS + IDX_BITS;
   localparam int POINTS     = 13;
   localparam int SCALE      = POINTS - 1;
   localparam int POS_BITS   = $clog2(POINTS);
   localparam int REF_BITS   = COORD_BITS + $clog2(SCALE + 1);
   localparam int SQ_BITS    = 2 * REF_BITS;
   localparam int DIST_BITS  = SQ_BITS + 1;
   localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);

   typedef struct packed {
      logic [COORD_BITS-1:0] spot_x;
      logic [COORD_BITS-1:0] spot_y;
      logic                  final_spot;
   } req_type;

   typedef struct packed {
      logic                  diagonal;
      logic [3:0]            position;
      logic [7:0]            chosen_index;
      logic [19:0]           chosen_x;
      logic [19:0]           chosen_y;
      logic                  end_of_run;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } spot_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIVX_GO,
      ST_DIVX_WAIT,
      ST_DIVY_GO,
      ST_DIVY_WAIT,
      ST_CORNER_RD,
      ST_CORNER_CMP,
      ST_REF_SET,
      ST_NEAR_RD,
      ST_NEAR_DX,
      ST_NEAR_DY,
      ST_NEAR_CMP,
      ST_OUT
   } state_type;

   // coordinate times the diagonal step count
   function automatic logic [REF_BITS-1:0] times_scale(input logic [COORD_BITS-1:0] v);
      times_scale = REF_BITS'(v) * REF_BITS'(SCALE);
   endfunction

   function automatic logic [REF_BITS-1:0] abs_diff(input logic [REF_BITS-1:0] a,
                                                    input logic [REF_BITS-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

### design/dgso_divider.sv
// restoring divider, one quotient bit per cycle, used for the mean point
`timescale 1ns / 1ps
module dgso_divider import dgso_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM_BITS-1:0] dividend,
   input  logic [CNT_BITS-1:0] divisor,
   output logic                busy,
   output logic [SUM_BITS-1:0] quotient
);

   logic [SUM_BITS-1:0]     quo_ff, quo_in;
   logic [CNT_BITS-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [CNT_BITS:0]       trial;

   assign trial = {rem_ff, quo_ff[SUM_BITS-1]};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = DIV_CNT_BITS'(SUM_BITS);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (trial >= {1'b0, divisor}) begin
            rem_in = CNT_BITS'(trial - {1'b0, divisor});
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

### design/dgso_store.sv
// spot store, one write port and one registered read port
`timescale 1ns / 1ps
module dgso_store import dgso_pkg::*; (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_BITS-1:0] wr_addr,
   input  spot_type            wr_data,
   input  logic                rd_en,
   input  logic [IDX_BITS-1:0] rd_addr,
   output spot_type            rd_data
);

   spot_type mem [MAX_SPOTS];
   spot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/diagonal_grid_spot_ordering_unit.sv
// top level: spot loading, mean, corner scan and nearest-spot search sequencer
`timescale 1ns / 1ps
// Spots arrive on the req_ channel, one beat per cycle while the unit is idle;
// each beat is written into the spot store and added to the running sums.
// A beat with final_spot set starts a run and the unit raises req_stall until
// the run is done. Beats beyond the store's 256 entries are dropped from the
// set, but a final one still starts the run over the spots held.
// A run: two divisions give the mean, x then y, then a corner scan reads and
// compares each stored spot; then for each of the 26 reference points every
// spot is read and its squared x then squared y offset taken on one shared
// 24x24 multiplier and compared, and the result beat goes out.
// Results leave on the rsp_ channel, first diagonal then second, 26 beats,
// end_of_run on the last one. rsp_stall simply holds the current beat and
// pauses the sequencer. The last beat taken clears count and sums.
// Reset (synchronous) empties the set and returns to idle; store contents
// are not cleared since only entries below the count are ever read.
module diagonal_grid_spot_ordering_unit import dgso_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type state_ff, state_in;

   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [SUM_BITS-1:0]   sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [COORD_BITS-1:0] mean_x_ff;
   spot_type              corner_ff [4];
   logic [CNT_BITS-1:0]   k_ff;
   logic                  diag_ff;
   logic [POS_BITS-1:0]   pos_ff;
   logic [REF_BITS-1:0]   rx_ff, ry_ff;
   logic [SQ_BITS-1:0]    sqx_ff, sqy_ff;
   logic [DIST_BITS-1:0]  best_dist_ff;
   logic [IDX_BITS-1:0]   best_idx_ff;
   spot_type              best_spot_ff;

   // decoded controls
   logic div_start, div_sel_y, mem_rd;
   logic req_take, rsp_take, k_last, pos_last, store_ok;

   logic                div_busy;
   logic [SUM_BITS-1:0] div_quo;
   spot_type            rd_spot, wr_spot;

   logic [REF_BITS-1:0]  mul_a;
   logic [SQ_BITS-1:0]   mul_p;
   logic [DIST_BITS-1:0] dist_sum;
   spot_type             s_pt, e_pt;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign store_ok = (count_ff < CNT_BITS'(MAX_SPOTS));
   assign k_last   = ((k_ff + 1'b1) == count_ff);
   assign pos_last = (pos_ff == POS_BITS'(POINTS - 1));
   assign wr_spot  = '{x: req_data.spot_x, y: req_data.spot_y};

   dgso_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_sel_y ? sum_y_ff : sum_x_ff),
      .divisor  (count_ff),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   dgso_store u_store (
      .clock   (clock),
      .wr_en   (req_take && store_ok),
      .wr_addr (count_ff[IDX_BITS-1:0]),
      .wr_data (wr_spot),
      .rd_en   (mem_rd),
      .rd_addr (k_ff[IDX_BITS-1:0]),
      .rd_data (rd_spot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (req_take && req_data.final_spot) state_in = ST_DIVX_GO;
         ST_DIVX_GO:    state_in = ST_DIVX_WAIT;
         ST_DIVX_WAIT:  if (!div_busy) state_in = ST_DIVY_GO;
         ST_DIVY_GO:    state_in = ST_DIVY_WAIT;
         ST_DIVY_WAIT:  if (!div_busy) state_in = ST_CORNER_RD;
         ST_CORNER_RD:  state_in = ST_CORNER_CMP;
         ST_CORNER_CMP: state_in = k_last ? ST_REF_SET : ST_CORNER_RD;
         ST_REF_SET:    state_in = ST_NEAR_RD;
         ST_NEAR_RD:    state_in = ST_NEAR_DX;
         ST_NEAR_DX:    state_in = ST_NEAR_DY;
         ST_NEAR_DY:    state_in = ST_NEAR_CMP;
         ST_NEAR_CMP:   state_in = k_last ? ST_OUT : ST_NEAR_RD;
         ST_OUT: begin
            if (rsp_take) begin
               state_in = (pos_last && diag_ff) ? ST_IDLE : ST_REF_SET;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // output decode
   always_comb begin
      div_start = 1'b0;
      div_sel_y = 1'b0;
      mem_rd    = 1'b0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE:      req_stall = 1'b0;
         ST_DIVX_GO:   div_start = 1'b1;
         ST_DIVY_GO: begin
            div_start = 1'b1;
            div_sel_y = 1'b1;
         end
         ST_CORNER_RD: mem_rd    = 1'b1;
         ST_NEAR_RD:   mem_rd    = 1'b1;
         ST_OUT:       rsp_valid = 1'b1;
         default:      ;
      endcase
   end

   // shared multiplier: x offset in one cycle, y offset in the next
   assign mul_a = (state_ff == ST_NEAR_DX) ? abs_diff(times_scale(rd_spot.x), rx_ff)
                                           : abs_diff(times_scale(rd_spot.y), ry_ff);
   assign mul_p = SQ_BITS'(mul_a) * SQ_BITS'(mul_a);
   assign dist_sum = DIST_BITS'(sqx_ff) + DIST_BITS'(sqy_ff);

   assign s_pt = diag_ff ? corner_ff[2] : corner_ff[0];
   assign e_pt = diag_ff ? corner_ff[3] : corner_ff[1];

   always_comb begin
      count_in = count_ff;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      if (req_take && store_ok) begin
         count_in = count_ff + 1'b1;
         sum_x_in = sum_x_ff + SUM_BITS'(req_data.spot_x);
         sum_y_in = sum_y_ff + SUM_BITS'(req_data.spot_y);
      end
      if (rsp_take && pos_last && diag_ff) begin
         count_in = '0;
         sum_x_in = '0;
         sum_y_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         diag_ff  <= 1'b0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         if (state_ff == ST_IDLE) begin
            diag_ff <= 1'b0;
            pos_ff  <= '0;
         end else if (rsp_take) begin
            if (pos_last) begin
               diag_ff <= 1'b1;
               pos_ff  <= '0;
            end else begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_DIVX_WAIT: begin
            if (!div_busy) mean_x_ff <= div_quo[COORD_BITS-1:0];
         end
         ST_DIVY_WAIT: begin
            if (!div_busy) begin
               for (int c = 0; c < 4; c++) begin
                  corner_ff[c] <= '{x: mean_x_ff, y: div_quo[COORD_BITS-1:0]};
               end
               k_ff <= '0;
            end
         end
         ST_CORNER_CMP: begin
            if (rd_spot.x > corner_ff[0].x && rd_spot.y > corner_ff[0].y) corner_ff[0] <= rd_spot;
            if (rd_spot.x < corner_ff[1].x && rd_spot.y < corner_ff[1].y) corner_ff[1] <= rd_spot;
            if (rd_spot.x < corner_ff[2].x && rd_spot.y > corner_ff[2].y) corner_ff[2] <= rd_spot;
            if (rd_spot.x > corner_ff[3].x && rd_spot.y < corner_ff[3].y) corner_ff[3] <= rd_spot;
            k_ff <= k_ff + 1'b1;
         end
         ST_REF_SET: begin
            // step along the diagonal by (end - start) at scaled resolution
            if (pos_ff == '0) begin
               rx_ff <= times_scale(s_pt.x);
               ry_ff <= times_scale(s_pt.y);
            end else begin
               rx_ff <= REF_BITS'(({1'b0, rx_ff} + (REF_BITS + 1)'(e_pt.x))
                                  - (REF_BITS + 1)'(s_pt.x));
               ry_ff <= REF_BITS'(({1'b0, ry_ff} + (REF_BITS + 1)'(e_pt.y))
                                  - (REF_BITS + 1)'(s_pt.y));
            end
            k_ff <= '0;
         end
         ST_NEAR_DX: sqx_ff <= mul_p;
         ST_NEAR_DY: sqy_ff <= mul_p;
         ST_NEAR_CMP: begin
            // strict compare keeps the earliest spot on ties
            if (k_ff == '0 || dist_sum < best_dist_ff) begin
               best_dist_ff <= dist_sum;
               best_idx_ff  <= k_ff[IDX_BITS-1:0];
               best_spot_ff <= rd_spot;
            end
            k_ff <= k_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_data.diagonal     = diag_ff;
      rsp_data.position     = 4'(pos_ff);
      rsp_data.chosen_index = 8'(best_idx_ff);
      rsp_data.chosen_x     = 20'(best_spot_ff.x);
      rsp_data.chosen_y     = 20'(best_spot_ff.y);
      rsp_data.end_of_run   = diag_ff && pos_last;
   end

   a_busy_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while a result is pending");
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (count_ff != '0))
      else $error("result produced with an empty spot set");
   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_data.end_of_run) |=> (count_ff == '0 && state_ff == ST_IDLE))
      else $error("run end did not clear the set");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pos_ff <= POS_BITS'(POINTS - 1)))
      else $error("position out of range");
   a_div_idle_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORNER_RD) |-> !div_busy)
      else $error("corner scan started before the mean was ready");

endmodule

### verif/tb_diagonal_grid_spot_ordering_unit.sv
// testbench for the diagonal grid spot ordering unit: spot sets in, ordered nearest spots checked
`timescale 1ns / 1ps

module tb_diagonal_grid_spot_ordering_unit import dgso_pkg::*; ();

   class spot_order_scoreboard;
      logic [COORD_BITS-1:0] held_x [MAX_SPOTS];
      logic [COORD_BITS-1:0] held_y [MAX_SPOTS];
      int unsigned           held_count;
      logic [63:0]           total_x, total_y;
      rsp_type               nearest_q[$];
      int                    mismatches;
      int                    beats_checked;

      function new();
         held_count    = 0;
         total_x       = 0;
         total_y       = 0;
         mismatches    = 0;
         beats_checked = 0;
      endfunction

      task report(input string what);
         mismatches++;
         $display("mismatch at %0t: %s", $time, what);
      endtask

      // squared distance of a held spot to a reference point kept at 12x scale
      function automatic logic [63:0] scaled_dist(int unsigned k, logic [63:0] rx,
                                                  logic [63:0] ry);
         logic [63:0] sx, sy, dx, dy;
         sx = 64'(held_x[k]) * SCALE;
         sy = 64'(held_y[k]) * SCALE;
         dx = (sx > rx) ? sx - rx : rx - sx;
         dy = (sy > ry) ? sy - ry : ry - sy;
         return dx * dx + dy * dy;
      endfunction

      function void note_spot(req_type beat);
         logic [63:0] mx, my, rx, ry, bd, dk;
         logic [63:0] cx [4];
         logic [63:0] cy [4];
         logic [63:0] sx, sy;
         int unsigned best;
         int          emitted;
         rsp_type     r;
         if (held_count < MAX_SPOTS) begin
            held_x[held_count] = beat.spot_x;
            held_y[held_count] = beat.spot_y;
            total_x += beat.spot_x;
            total_y += beat.spot_y;
            held_count++;
         end
         if (!beat.final_spot) return;
         mx = total_x / held_count;
         my = total_y / held_count;
         for (int c = 0; c < 4; c++) begin
            cx[c] = mx;
            cy[c] = my;
         end
         for (int unsigned k = 0; k < held_count; k++) begin
            sx = held_x[k];
            sy = held_y[k];
            if (sx > cx[0] && sy > cy[0]) begin cx[0] = sx; cy[0] = sy; end
            if (sx < cx[1] && sy < cy[1]) begin cx[1] = sx; cy[1] = sy; end
            if (sx > cx[3] && sy < cy[3]) begin cx[3] = sx; cy[3] = sy; end
            if (sx < cx[2] && sy > cy[2]) begin cx[2] = sx; cy[2] = sy; end
         end
         emitted = 0;
         for (int d = 0; d < 2; d++) begin
            for (int i = 0; i < POINTS; i++) begin
               rx = cx[2*d] * (SCALE - i) + cx[2*d+1] * i;
               ry = cy[2*d] * (SCALE - i) + cy[2*d+1] * i;
               best = 0;
               bd = scaled_dist(0, rx, ry);
               for (int unsigned k = 1; k < held_count; k++) begin
                  dk = scaled_dist(k, rx, ry);
                  if (dk < bd) begin
                     bd = dk;
                     best = k;
                  end
               end
               emitted++;
               r.diagonal     = d[0];
               r.position     = i[3:0];
               r.chosen_index = best[7:0];
               r.chosen_x     = held_x[best];
               r.chosen_y     = held_y[best];
               r.end_of_run   = (emitted == 2 * POINTS);
               nearest_q.insert(nearest_q.size(), r);
            end
         end
         held_count = 0;
         total_x = 0;
         total_y = 0;
      endfunction

      task check_result(rsp_type got);
         rsp_type e;
         beats_checked++;
         if (nearest_q.size() == 0) begin
            report($sformatf("result beat with nothing expected: %h", got));
            return;
         end
         e = nearest_q.pop_front();
         if (got.diagonal !== e.diagonal)
            report($sformatf("diagonal got %0d want %0d", got.diagonal, e.diagonal));
         if (got.position !== e.position)
            report($sformatf("position got %0d want %0d", got.position, e.position));
         if (got.chosen_index !== e.chosen_index)
            report($sformatf("chosen_index got %0d want %0d (pos %0d diag %0d)",
                             got.chosen_index, e.chosen_index, e.position, e.diagonal));
         if (got.chosen_x !== e.chosen_x)
            report($sformatf("chosen_x got %h want %h", got.chosen_x, e.chosen_x));
         if (got.chosen_y !== e.chosen_y)
            report($sformatf("chosen_y got %h want %h", got.chosen_y, e.chosen_y));
         if (got.end_of_run !== e.end_of_run)
            report($sformatf("end_of_run got %0d want %0d", got.end_of_run, e.end_of_run));
      endtask

      function int pending();
         return nearest_q.size();
      endfunction
   endclass

   localparam int QUIET_LIMIT = 40000;
   localparam int LONG_HOLD   = 3000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   spot_order_scoreboard sb = new();

   int sender_idle_pct = 0;
   int stall_pct       = 0;
   bit long_hold_ask   = 1'b0;
   int hold_left       = 0;
   int quiet_cycles    = 0;
   int spots_sent      = 0;
   int sets_sent       = 0;

   diagonal_grid_spot_ordering_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // receiver stall, with an occasional long hold-off
   always @(negedge clock) begin
      if (long_hold_ask) begin
         long_hold_ask = 1'b0;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results pending",
                  quiet_cycles, sb.pending());
         $display("CHECK FAILED");
         $finish;
      end
   end

   task send_spot(input logic [19:0] x, input logic [19:0] y, input bit fin);
      req_type beat;
      bit taken;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      beat.spot_x = x;
      beat.spot_y = y;
      beat.final_spot = fin;
      req_data  = beat;
      req_valid = 1'b1;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
         @(negedge clock);
      end
      req_valid = 1'b0;
      sb.note_spot(beat);
      spots_sent++;
      if (fin) sets_sent++;
   endtask

   task set_idling(input int phase);
      case (phase % 4)
         0: begin sender_idle_pct = 0;  stall_pct = 0;  end
         1: begin sender_idle_pct = 52; stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  stall_pct = 52; end
         default: begin sender_idle_pct = 32; stall_pct = 32; end
      endcase
   endtask

   // one spot set: mostly jittered grids, some scattered or extreme spots
   task send_random_set(input int n);
      logic [19:0] ox, oy, pitch, x, y;
      int cols, c, r;
      ox = 20'($urandom_range(20'h90000));
      oy = 20'($urandom_range(20'h90000));
      pitch = 20'($urandom_range(20'h4000, 16));
      cols = $urandom_range(6, 2);
      for (int k = 0; k < n; k++) begin
         c = $urandom_range(cols - 1);
         r = $urandom_range(cols - 1);
         case ($urandom_range(9))
            7: begin x = 20'($urandom); y = 20'($urandom); end
            8: begin
               x = 20'(20'hFFFFF - $urandom_range(255));
               y = 20'($urandom_range(255));
            end
            9: begin x = ox; y = oy; end
            default: begin
               x = 20'(ox + c * pitch + $urandom_range(pitch / 8));
               y = 20'(oy + r * pitch + $urandom_range(pitch / 8));
            end
         endcase
         send_spot(x, y, k == n - 1);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: single spot, corners of the range, ties, coincident, vertical line
      set_idling(0);
      send_spot(20'h0, 20'h0, 1'b1);
      send_spot(20'hFFFFF, 20'hFFFFF, 1'b0);
      send_spot(20'h0, 20'h0, 1'b0);
      send_spot(20'hFFFFF, 20'h0, 1'b0);
      send_spot(20'h0, 20'hFFFFF, 1'b0);
      send_spot(20'h80000, 20'h80000, 1'b1);
      set_idling(3);
      send_spot(20'h100, 20'h100, 1'b0);
      send_spot(20'h100, 20'h100, 1'b0);
      send_spot(20'h300, 20'h300, 1'b0);
      send_spot(20'h300, 20'h300, 1'b1);
      send_spot(20'h5555, 20'hAAAA, 1'b0);
      send_spot(20'h5555, 20'hAAAA, 1'b0);
      send_spot(20'h5555, 20'hAAAA, 1'b1);
      send_spot(20'h1234, 20'h0, 1'b0);
      send_spot(20'h1234, 20'h4000, 1'b0);
      send_spot(20'h1234, 20'h8000, 1'b0);
      send_spot(20'h1234, 20'hC000, 1'b1);

      // random small sets, idling phase rotating per set
      while (sets_sent < 10) begin
         set_idling(sets_sent);
         if (sets_sent % 11 == 5) long_hold_ask = 1'b1;
         r_set: begin
            int n;
            n = $urandom_range(4, 1);
            send_random_set(n);
         end
      end

      // full store: the extra spots, final one included, are dropped
      set_idling(2);
      long_hold_ask = 1'b1;
      send_random_set(258);

      while (sb.pending() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d spots in %0d sets, %0d result beats checked",
               spots_sent, sets_sent, sb.beats_checked);
      $display("incl. single-spot, tie, coincident-corner and full-store sets");
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### files.f
design/dgso_pkg.sv
design/dgso_divider.sv
design/dgso_store.sv
design/diagonal_grid_spot_ordering_unit.sv
verif/tb_diagonal_grid_spot_ordering_unit.sv
